/* src/mh3_pkg.sv */
// Shared constants and types for the streaming MurmurHash3 x86_32 block.
// No dependencies; imported by every module under src.
package mh3_pkg;

   localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2     = 32'h1b873593;
   localparam logic [31:0] SEED_RESET = 32'h9e3779b9;
   localparam logic [31:0] STEP_ADD   = 32'he6546b64;
   localparam logic [31:0] FIN_C1     = 32'h85ebca6b;
   localparam logic [31:0] FIN_C2     = 32'hc2b2ae35;

   localparam int          REQ_TDATA_W = 40;
   localparam logic [2:0]  FULL_BYTES  = 3'd4;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   typedef enum logic [1:0] {
      KIND_BLOCK,
      KIND_TAIL,
      KIND_NONE
   } mix_kind_type;

   typedef struct packed {
      logic [31:0]  key;
      logic [2:0]   nbytes;
      mix_kind_type kind;
      logic         last;
   } entry_type;

endpackage

/* src/mh3_front.sv */
// Front end: accepts words, classifies block/tail/empty and runs the pipelined key mix.
// Depends on mh3_pkg.
module mh3_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [31:0] data_word, [34:32] byte_count, [39:35] zero
   input  logic [mh3_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   output logic                           push_valid,
   input  logic                           push_ready,
   output mh3_pkg::entry_type             push_entry
);
   import mh3_pkg::*;

   function automatic logic [31:0] byte_mask(input logic [2:0] count);
      logic [31:0] m;
      unique case (count)
         3'd1:    m = 32'h0000_00ff;
         3'd2:    m = 32'h0000_ffff;
         3'd3:    m = 32'h00ff_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

   logic        s1_valid_ff;
   logic        s2_valid_ff;
   entry_type   s1_ff, s1_in;
   entry_type   s2_ff, s2_in;
   logic        s1_ready;
   logic        s2_ready;
   logic [31:0] word;
   logic [2:0]  count;
   logic [31:0] mask;
   logic [31:0] k_rot;

   assign word  = req_tdata[31:0];
   assign count = req_tdata[34:32];

   always_comb begin
      s1_in.last = req_tlast;
      if (!req_tlast || count >= FULL_BYTES) begin
         s1_in.kind   = KIND_BLOCK;
         s1_in.nbytes = FULL_BYTES;
         mask         = 32'hffff_ffff;
      end else if (count != 3'd0) begin
         s1_in.kind   = KIND_TAIL;
         s1_in.nbytes = count;
         mask         = byte_mask(count);
      end else begin
         s1_in.kind   = KIND_NONE;
         s1_in.nbytes = 3'd0;
         mask         = 32'h0000_0000;
      end
      s1_in.key = 32'((word & mask) * MIX_C1);
   end

   assign k_rot = {s1_ff.key[16:0], s1_ff.key[31:17]};

   always_comb begin
      s2_in     = s1_ff;
      s2_in.key = 32'(k_rot * MIX_C2);
   end

   assign s2_ready   = !s2_valid_ff || push_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign push_valid = s2_valid_ff;
   assign push_entry = s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && s1_ready) begin
         s1_ff <= s1_in;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_ff <= s2_in;
      end
   end

endmodule

/* src/mh3_fifo.sv */
// Short queue of mixed keys between the front end and the hash update.
// Depends on mh3_pkg.
module mh3_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mh3_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop_ready,
   output mh3_pkg::entry_type pop_entry
);
   import mh3_pkg::*;

   entry_type      mem_ff [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff;
   logic [QAW-1:0] rd_ptr_ff;
   logic [QAW:0]   count_ff;
   logic           push;
   logic           pop;

   assign push_ready = (count_ff != (QAW+1)'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QAW+1)'(QDEPTH))
      else $error("queue count beyond depth");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop without push did not drain one entry");

endmodule

/* src/mh3_back.sv */
// Back end: running hash update, length tracking and multi-cycle fmix32 finalizer.
// Depends on mh3_pkg; fed by mh3_fifo.
module mh3_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [31:0]        seed,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  mh3_pkg::entry_type pop_entry,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // [31:0] hash_value
   output logic [31:0]        rsp_tdata
);
   import mh3_pkg::*;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FIN_A,
      ST_FIN_B,
      ST_FIN_C
   } state_type;

   state_type   state_ff;
   logic [31:0] hash_ff;
   logic [31:0] len_ff;
   logic        mid_ff;
   logic [31:0] fin_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   logic [31:0] h_base;
   logic [31:0] h_xor;
   logic [31:0] h_rot;
   logic [31:0] h_new;
   logic [31:0] len_new;
   logic [31:0] fin_a;
   logic [31:0] fin_b;
   logic        pop;
   logic        rsp_load;

   assign pop_ready  = (state_ff == ST_RUN);
   assign pop        = pop_valid && pop_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_load   = (state_ff == ST_FIN_C) && (!rsp_valid_ff || rsp_tready);

   assign h_base  = mid_ff ? hash_ff : seed;
   assign h_xor   = h_base ^ pop_entry.key;
   assign h_rot   = {h_xor[18:0], h_xor[31:19]};
   assign len_new = len_ff + {29'd0, pop_entry.nbytes};
   assign fin_a   = fin_ff ^ (fin_ff >> 16);
   assign fin_b   = fin_ff ^ (fin_ff >> 13);

   always_comb begin
      unique case (pop_entry.kind)
         KIND_BLOCK: h_new = (h_rot << 2) + h_rot + STEP_ADD;
         KIND_TAIL:  h_new = h_xor;
         KIND_NONE:  h_new = h_base;
         default:    h_new = h_base;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         len_ff       <= '0;
         mid_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_RUN: begin
               if (pop) begin
                  if (pop_entry.last) begin
                     fin_ff   <= h_new ^ len_new;
                     len_ff   <= '0;
                     mid_ff   <= 1'b0;
                     state_ff <= ST_FIN_A;
                  end else begin
                     hash_ff <= h_new;
                     len_ff  <= len_new;
                     mid_ff  <= 1'b1;
                  end
               end
            end
            ST_FIN_A: begin
               fin_ff   <= 32'(fin_a * FIN_C1);
               state_ff <= ST_FIN_B;
            end
            ST_FIN_B: begin
               fin_ff   <= 32'(fin_b * FIN_C2);
               state_ff <= ST_FIN_C;
            end
            ST_FIN_C: begin
               if (rsp_load) begin
                  rsp_data_ff <= fin_ff ^ (fin_ff >> 16);
                  state_ff    <= ST_RUN;
               end
            end
            default: state_ff <= ST_RUN;
         endcase
      end
   end

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      pop && pop_entry.last |=> state_ff == ST_FIN_A && len_ff == '0 && !mid_ff)
      else $error("last word did not start finalize and clear message state");

   a_fin_sequence: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN_A |=> state_ff == ST_FIN_B)
      else $error("finalize step skipped");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FIN_C)
      else $error("result raised outside final finalize step");

endmodule

/* src/murmur3_32_stream_hash.sv */
// Streaming MurmurHash3 x86_32: one little-endian word per transfer, hash out on tlast.
// Throughput: one word per cycle while the update stage is free; after the last word it
// takes none until fmix32 has run its three registered finalize steps (two multiplies,
// then the final xor-shift) and loaded the hash for output. The last word passes two
// key-mix stages, queue, update, finalize. Reset: seed 0x9e3779b9, pipeline, queue empty.
// Depends on mh3_pkg, mh3_front, mh3_fifo, mh3_back.
module murmur3_32_stream_hash (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [31:0]                     csr_wr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] data_word, [34:32] byte_count, [39:35] zero
   input  logic [mh3_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] hash_value
   output logic [31:0]                     rsp_tdata
);
   import mh3_pkg::*;

   logic [31:0] seed_ff;
   logic        push_valid;
   logic        push_ready;
   entry_type   push_entry;
   logic        pop_valid;
   logic        pop_ready;
   entry_type   pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else if (csr_wr_en) begin
         seed_ff <= csr_wr_data;
      end
   end

   mh3_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   mh3_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   mh3_back u_back (
      .clock      (clock),
      .reset      (reset),
      .seed       (seed_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
